### design/patterned_line_rasterizer_core_assert.svh
// Assertion macros used by the back stage of the rasterizer.
`ifndef PATTERNED_LINE_RASTERIZER_CORE_ASSERT_SVH
`define PATTERNED_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PLR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rasterizer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PLR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rasterizer assertion failed");

`endif

### design/plr_pkg.sv
// Shared types, constants and the dash table of the patterned line rasterizer.
package plr_pkg;

   localparam int COORD_BITS     = 12;
   localparam int DIM_BITS       = COORD_BITS + 1;
   localparam int COLOR_BITS     = 24;
   localparam int STYLE_BITS     = 3;
   localparam int STYLE_COUNT    = 7;
   localparam int PATTERN_LENGTH = 12;
   localparam int PHASE_BITS     = 4;
   localparam int PROD_BITS      = 2 * DIM_BITS;
   localparam int CROSS_BITS     = PROD_BITS + 1;
   localparam int BAND_BITS      = COORD_BITS + 5;
   localparam int ADDR_BITS      = 4;
   localparam int DATA_BITS      = 32;

   localparam logic [STYLE_BITS:0] STYLE_LIMIT = (STYLE_BITS + 1)'(STYLE_COUNT);
   localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(PATTERN_LENGTH - 1);

   localparam logic [DIM_BITS-1:0]   SCREEN_WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0]   SCREEN_HEIGHT_RESET = DIM_BITS'(480);
   localparam logic [COLOR_BITS-1:0] BACKGROUND_RESET    = '0;

   // Bit i of each mask is pattern entry i; the last style code never loads.
   localparam logic [PATTERN_LENGTH-1:0] DASH_MASK [8] = '{
      12'hFFF, 12'h03F, 12'hAAA, 12'h1F1, 12'h1FF, 12'h3E7, 12'h888, 12'h000
   };

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_IDLE   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_SCREEN_WIDTH  = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_BACKGROUND    = 2'd2
   } reg_index_type;

   // One request after the front stage: position, products and line attributes.
   typedef struct packed {
      status_type                   status;
      logic                         load_ok;
      logic                         step_act;
      logic [COORD_BITS-1:0]        px;
      logic [COORD_BITS-1:0]        py;
      logic signed [PROD_BITS-1:0]  prod_y;
      logic signed [PROD_BITS-1:0]  prod_x;
      logic [COORD_BITS-1:0]        dx_abs;
      logic                         dx_zero;
      logic                         last;
      logic [COLOR_BITS-1:0]        color;
      logic [STYLE_BITS-1:0]        style;
   } stage_type;

endpackage

### design/plr_csr.sv
// Configuration registers of the rasterizer behind an APB-style port.
module plr_csr
   import plr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]  prdata,
   output logic                  pready,
   output logic [DIM_BITS-1:0]   screen_width,
   output logic [DIM_BITS-1:0]   screen_height,
   output logic [COLOR_BITS-1:0] background_color
);

   logic [DIM_BITS-1:0]   width_ff, width_in;
   logic [DIM_BITS-1:0]   height_ff, height_in;
   logic [COLOR_BITS-1:0] bg_ff, bg_in;
   reg_index_type         index;
   logic                  wr_en;

   assign index = reg_index_type'(paddr[3:2]);
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bg_in     = bg_ff;
      if (wr_en) begin
         case (index)
            REG_SCREEN_WIDTH:  width_in  = pwdata[DIM_BITS-1:0];
            REG_SCREEN_HEIGHT: height_in = pwdata[DIM_BITS-1:0];
            REG_BACKGROUND:    bg_in     = pwdata[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SCREEN_WIDTH:  prdata = DATA_BITS'(width_ff);
         REG_SCREEN_HEIGHT: prdata = DATA_BITS'(height_ff);
         REG_BACKGROUND:    prdata = DATA_BITS'(bg_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
         bg_ff     <= BACKGROUND_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bg_ff     <= bg_in;
      end
   end

   assign screen_width     = width_ff;
   assign screen_height    = height_ff;
   assign background_color = bg_ff;

endmodule

### design/plr_front.sv
// Line state, bounding-box cursor and cross-product multipliers of the rasterizer.
module plr_front
   import plr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   input  logic [COLOR_BITS-1:0] req_line_color,
   input  logic [STYLE_BITS-1:0] req_line_style,
   input  logic [DIM_BITS-1:0]   screen_width,
   input  logic [DIM_BITS-1:0]   screen_height,
   input  logic                  back_ready,
   output logic                  stage_valid,
   output stage_type             stage
);

   logic                         active_ff, active_in;
   logic [COORD_BITS-1:0]        cur_col_ff, cur_col_in;
   logic [COORD_BITS-1:0]        cur_row_ff, cur_row_in;
   logic [COORD_BITS-1:0]        col_min_ff, col_min_in;
   logic [COORD_BITS-1:0]        col_max_ff, col_max_in;
   logic [COORD_BITS-1:0]        row_min_ff, row_min_in;
   logic [COORD_BITS-1:0]        row_max_ff, row_max_in;
   logic [COORD_BITS-1:0]        org_col_ff, org_col_in;
   logic [COORD_BITS-1:0]        org_row_ff, org_row_in;
   logic signed [DIM_BITS-1:0]   dcol_ff, dcol_in;
   logic signed [DIM_BITS-1:0]   drow_ff, drow_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;
   logic [STYLE_BITS-1:0]        style_ff, style_in;
   logic                         stage_valid_ff, stage_valid_in;
   stage_type                    stage_ff, stage_in;

   logic                         advance;
   logic                         accept;
   logic                         load_ok;
   logic                         at_end;
   logic signed [DIM_BITS-1:0]   rel_row;
   logic signed [DIM_BITS-1:0]   rel_col;
   logic signed [DIM_BITS-1:0]   dcol_abs;

   assign advance   = !stage_valid_ff || back_ready;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   assign load_ok = ({1'b0, req_x_start} < screen_width) &&
                    ({1'b0, req_x_end} < screen_width) &&
                    ({1'b0, req_y_start} < screen_height) &&
                    ({1'b0, req_y_end} < screen_height) &&
                    ({1'b0, req_line_style} < STYLE_LIMIT);

   assign rel_row  = signed'({1'b0, cur_row_ff}) - signed'({1'b0, org_row_ff});
   assign rel_col  = signed'({1'b0, cur_col_ff}) - signed'({1'b0, org_col_ff});
   assign dcol_abs = dcol_ff[DIM_BITS-1] ? -dcol_ff : dcol_ff;
   assign at_end   = (cur_col_ff == col_max_ff) && (cur_row_ff == row_max_ff);

   always_comb begin
      active_in  = active_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      col_min_in = col_min_ff;
      col_max_in = col_max_ff;
      row_min_in = row_min_ff;
      row_max_in = row_max_ff;
      org_col_in = org_col_ff;
      org_row_in = org_row_ff;
      dcol_in    = dcol_ff;
      drow_in    = drow_ff;
      color_in   = color_ff;
      style_in   = style_ff;

      stage_in          = '0;
      stage_in.status   = STATUS_OK;
      stage_in.color    = color_ff;
      stage_in.style    = style_ff;
      stage_in.dx_abs   = dcol_abs[COORD_BITS-1:0];
      stage_in.dx_zero  = (dcol_ff == '0);

      if (accept) begin
         if (op_type'(req_op) == OP_LOAD) begin
            if (load_ok) begin
               stage_in.load_ok = 1'b1;
               active_in  = 1'b1;
               org_col_in = req_x_start;
               org_row_in = req_y_start;
               dcol_in    = signed'({1'b0, req_x_end}) - signed'({1'b0, req_x_start});
               drow_in    = signed'({1'b0, req_y_end}) - signed'({1'b0, req_y_start});
               col_min_in = (req_x_start < req_x_end) ? req_x_start : req_x_end;
               col_max_in = (req_x_start < req_x_end) ? req_x_end : req_x_start;
               row_min_in = (req_y_start < req_y_end) ? req_y_start : req_y_end;
               row_max_in = (req_y_start < req_y_end) ? req_y_end : req_y_start;
               cur_col_in = col_min_in;
               cur_row_in = row_min_in;
               color_in   = req_line_color;
               style_in   = req_line_style;
            end else begin
               stage_in.status = STATUS_REJECT;
            end
         end else if (!active_ff) begin
            stage_in.status = STATUS_IDLE;
         end else begin
            stage_in.step_act = 1'b1;
            stage_in.px       = cur_col_ff;
            stage_in.py       = cur_row_ff;
            stage_in.prod_y   = PROD_BITS'(rel_row) * PROD_BITS'(dcol_ff);
            stage_in.prod_x   = PROD_BITS'(rel_col) * PROD_BITS'(drow_ff);
            stage_in.last     = at_end;
            // Rows run fastest; the column moves on when a row sweep ends.
            if (at_end) begin
               active_in = 1'b0;
            end else if (cur_row_ff >= row_max_ff) begin
               cur_row_in = row_min_ff;
               cur_col_in = cur_col_ff + 1'b1;
            end else begin
               cur_row_in = cur_row_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (advance) begin
         stage_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         col_min_ff     <= '0;
         col_max_ff     <= '0;
         row_min_ff     <= '0;
         row_max_ff     <= '0;
         org_col_ff     <= '0;
         org_row_ff     <= '0;
         dcol_ff        <= '0;
         drow_ff        <= '0;
         color_ff       <= '0;
         style_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         active_ff      <= active_in;
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         col_min_ff     <= col_min_in;
         col_max_ff     <= col_max_in;
         row_min_ff     <= row_min_in;
         row_max_ff     <= row_max_in;
         org_col_ff     <= org_col_in;
         org_row_ff     <= org_row_in;
         dcol_ff        <= dcol_in;
         drow_ff        <= drow_in;
         color_ff       <= color_in;
         style_ff       <= style_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

endmodule

### design/plr_back.sv
// Band test, dash pattern and result register of the rasterizer.
`include "patterned_line_rasterizer_core_assert.svh"

module plr_back
   import plr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  stage_valid,
   input  stage_type             stage,
   input  logic [COLOR_BITS-1:0] background_color,
   output logic                  back_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic                  rsp_pixel_write,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_last
);

   logic                         valid_ff, valid_in;
   logic [PHASE_BITS-1:0]        phase_ff, phase_in;
   status_type                   status_ff;
   logic                         write_ff;
   logic [COORD_BITS-1:0]        x_ff;
   logic [COORD_BITS-1:0]        y_ff;
   logic [COLOR_BITS-1:0]        color_ff, color_in;
   logic                         last_ff;

   logic                         take;
   logic                         drawn;
   logic signed [CROSS_BITS-1:0] cross_sum;
   logic [CROSS_BITS:0]          lhs;
   logic [BAND_BITS-1:0]         rhs;

   assign back_ready = !valid_ff || !rsp_stall;
   assign take       = stage_valid && back_ready;

   // The band of half-width 10.5 is scaled by two: 2*|cross| <= 21*|dx|.
   assign cross_sum = CROSS_BITS'(stage.prod_y) - CROSS_BITS'(stage.prod_x);
   assign lhs   = {(cross_sum[CROSS_BITS-1] ? -cross_sum : cross_sum), 1'b0};
   assign rhs   = (BAND_BITS'(stage.dx_abs) << 4) + (BAND_BITS'(stage.dx_abs) << 2) +
                  BAND_BITS'(stage.dx_abs);
   assign drawn = stage.step_act && (stage.dx_zero || (lhs <= (CROSS_BITS + 1)'(rhs)));

   always_comb begin
      phase_in = phase_ff;
      color_in = '0;
      if (drawn) begin
         color_in = DASH_MASK[stage.style][phase_ff] ? stage.color : background_color;
      end
      if (take) begin
         if (stage.load_ok) begin
            phase_in = '0;
         end else if (drawn) begin
            phase_in = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 1'b1;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= stage.status;
         write_ff  <= drawn;
         x_ff      <= stage.px;
         y_ff      <= stage.py;
         color_ff  <= color_in;
         last_ff   <= stage.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_pixel_write = write_ff;
   assign rsp_pixel_x     = x_ff;
   assign rsp_pixel_y     = y_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_last        = last_ff;

   `PLR_ASSERT_IMP(a_phase_range, clock, reset, 1'b1, phase_ff <= PHASE_LAST)
   `PLR_ASSERT_NEXT(a_phase_restart, clock, reset, take && stage.load_ok, phase_ff == '0)
   `PLR_ASSERT_IMP(a_bad_status_quiet, clock, reset,
                   valid_ff && (status_ff != STATUS_OK), !write_ff && !last_ff)
   `PLR_ASSERT_IMP(a_gap_color, clock, reset, valid_ff && !write_ff, color_ff == '0)

endmodule

### design/patterned_line_rasterizer_core.sv
// Top level of the patterned line rasterizer: register port, front stage, back stage.
//
//  Channel   Direction  Handshake           Payload
//  req_*     in         req_valid/stall     op, endpoints, line color, line style
//  rsp_*     out        rsp_valid/stall     status, pixel write, x, y, color, last
//  apb       in/out     psel/penable/pready screen width, screen height, background
//
// A request passes from acceptance to its result through the front stage register,
// where the cursor moves and the two cross products are multiplied, and then the
// back stage, where the band test and the dash pattern fill the result register.
// One request is accepted every cycle while the result side does not stall.
// Reset is synchronous and leaves no line active, with the pattern at its start.
// A stalled result holds; the front stage keeps taking requests until it is full.
module patterned_line_rasterizer_core
   import plr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   input  logic [COLOR_BITS-1:0] req_line_color,
   input  logic [STYLE_BITS-1:0] req_line_style,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic                  rsp_pixel_write,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]  prdata,
   output logic                  pready
);

   logic [DIM_BITS-1:0]   screen_width;
   logic [DIM_BITS-1:0]   screen_height;
   logic [COLOR_BITS-1:0] background_color;
   logic                  back_ready;
   logic                  stage_valid;
   stage_type             stage;

   plr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .screen_width     (screen_width),
      .screen_height    (screen_height),
      .background_color (background_color)
   );

   plr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_line_color (req_line_color),
      .req_line_style (req_line_style),
      .screen_width   (screen_width),
      .screen_height  (screen_height),
      .back_ready     (back_ready),
      .stage_valid    (stage_valid),
      .stage          (stage)
   );

   plr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .stage_valid      (stage_valid),
      .stage            (stage),
      .background_color (background_color),
      .back_ready       (back_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_pixel_write  (rsp_pixel_write),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last         (rsp_last)
   );

endmodule
